@@ hdl/ows_pkg.sv @@
// ----------------------------------------------------------------------------
// ows_pkg
// Shared types, codes and sizes for the ROM search decision block.
// ----------------------------------------------------------------------------
package ows_pkg;

    // ROM code length and derived widths
    localparam int ROM_BITS     = 64;
    localparam int POS_W        = $clog2(ROM_BITS + 1);
    localparam int IDX_W        = $clog2(ROM_BITS);
    localparam int FAMILY_LIMIT = 9;
    localparam int FAM_W        = 4;
    localparam int CNT_W        = 8;
    localparam int LIMIT_RESET  = 8;

    // Result queue size: one request can give two results
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

    // Request operation codes
    localparam logic [1:0] OP_RESTART = 2'd0;
    localparam logic [1:0] OP_BEGIN   = 2'd1;
    localparam logic [1:0] OP_PAIR    = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_DIR     = 2'd0;
    localparam logic [1:0] ST_FOUND   = 2'd1;
    localparam logic [1:0] ST_NONE    = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic       presence;
        logic       id_bit;
        logic       complement_bit;
    } t_item;

    typedef struct packed {
        logic [1:0]          status;
        logic                direction_bit;
        logic [ROM_BITS-1:0] found_rom;
        logic                last_device;
        logic [FAM_W-1:0]    family_mark;
        logic [CNT_W-1:0]    found_count;
    } t_result;

    // Build one result record
    function automatic t_result mk_result(
        input logic [1:0]          status,
        input logic                dir,
        input logic [ROM_BITS-1:0] rom,
        input logic                last,
        input logic [FAM_W-1:0]    fam,
        input logic [CNT_W-1:0]    cnt
    );
        t_result r;
        r.status        = status;
        r.direction_bit = dir;
        r.found_rom     = rom;
        r.last_device   = last;
        r.family_mark   = fam;
        r.found_count   = cnt;
        return r;
    endfunction

endpackage

@@ hdl/ows_core.sv @@
// ----------------------------------------------------------------------------
// ows_core
// Search state and per-request decision logic. Updates the state on each
// processed request and hands up to two results to the result queue.
// ----------------------------------------------------------------------------
module ows_core import ows_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  t_item            i_item,
    input  logic [CNT_W-1:0] i_device_limit,
    output t_result          o_res0,
    output t_result          o_res1,
    output logic [1:0]       o_push_n
);

    logic [ROM_BITS-1:0] r_rom,         n_rom;
    logic [POS_W-1:0]    r_pos,         n_pos;
    logic [POS_W-1:0]    r_last_zero,   n_last_zero;
    logic [POS_W-1:0]    r_last_branch, n_last_branch;
    logic [FAM_W-1:0]    r_family,      n_family;
    logic                r_last_seen,   n_last_seen;
    logic                r_active,      n_active;
    logic [CNT_W-1:0]    r_found,       n_found;

    logic [IDX_W-1:0]    idx;
    logic                dir;

    assign idx = IDX_W'(r_pos - POS_W'(1));

    // Decide direction, advance the walk and build results
    always_comb begin
        n_rom         = r_rom;
        n_pos         = r_pos;
        n_last_zero   = r_last_zero;
        n_last_branch = r_last_branch;
        n_family      = r_family;
        n_last_seen   = r_last_seen;
        n_active      = r_active;
        n_found       = r_found;
        dir           = 1'b0;
        o_res0        = '0;
        o_res1        = '0;
        o_push_n      = 2'd0;
        if (i_fire) begin
            unique case (i_item.op)
                OP_RESTART: begin
                    n_last_branch = '0;
                    n_family      = '0;
                    n_last_seen   = 1'b0;
                    n_found       = '0;
                    n_active      = 1'b0;
                end
                OP_BEGIN: begin
                    n_active = 1'b0;
                    if (r_found >= i_device_limit) begin
                        o_res0   = mk_result(ST_NONE, 1'b0, '0, 1'b0, r_family, r_found);
                        o_push_n = 2'd1;
                    end else if (r_last_seen || !i_item.presence) begin
                        n_last_branch = '0;
                        n_family      = '0;
                        n_last_seen   = 1'b0;
                        o_res0   = mk_result(ST_NONE, 1'b0, '0, 1'b0, '0, r_found);
                        o_push_n = 2'd1;
                    end else begin
                        n_active    = 1'b1;
                        n_pos       = POS_W'(1);
                        n_last_zero = '0;
                    end
                end
                OP_PAIR: begin
                    if (r_active) begin
                        if (i_item.id_bit && i_item.complement_bit) begin
                            // no device answered: drop the pass
                            n_active      = 1'b0;
                            n_last_branch = '0;
                            n_family      = '0;
                            n_last_seen   = 1'b0;
                            o_res0   = mk_result(ST_NONE, 1'b0, '0, 1'b0, '0, r_found);
                            o_push_n = 2'd1;
                        end else begin
                            if (i_item.id_bit != i_item.complement_bit) begin
                                dir = i_item.id_bit;
                            end else begin
                                // discrepancy: follow the stored path below the branch, take 1 on it, 0 above
                                if (r_pos < r_last_branch) begin
                                    dir = r_rom[idx];
                                end else begin
                                    dir = (r_pos == r_last_branch);
                                end
                                if (!dir) begin
                                    n_last_zero = r_pos;
                                    if (r_pos < POS_W'(FAMILY_LIMIT)) begin
                                        n_family = FAM_W'(r_pos);
                                    end
                                end
                            end
                            n_rom[idx] = dir;
                            n_pos      = r_pos + POS_W'(1);
                            o_res0     = mk_result(ST_DIR, dir, '0, 1'b0, n_family, r_found);
                            o_push_n   = 2'd1;
                            // close the pass after the last bit
                            if (r_pos == POS_W'(ROM_BITS)) begin
                                n_active      = 1'b0;
                                n_last_branch = n_last_zero;
                                if (n_last_zero == '0) begin
                                    n_last_seen = 1'b1;
                                end
                                if (n_rom[7:0] == 8'd0) begin
                                    n_last_branch = '0;
                                    n_family      = '0;
                                    n_last_seen   = 1'b0;
                                    o_res1 = mk_result(ST_NONE, 1'b0, '0, 1'b0, '0, r_found);
                                end else begin
                                    if (r_found != {CNT_W{1'b1}}) begin
                                        n_found = r_found + CNT_W'(1);
                                    end
                                    o_res1 = mk_result(ST_FOUND, 1'b0, n_rom, n_last_seen,
                                                       n_family, n_found);
                                end
                                o_push_n = 2'd2;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Hold the search state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom         <= '0;
            r_pos         <= POS_W'(1);
            r_last_zero   <= '0;
            r_last_branch <= '0;
            r_family      <= '0;
            r_last_seen   <= 1'b0;
            r_active      <= 1'b0;
            r_found       <= '0;
        end else begin
            r_rom         <= n_rom;
            r_pos         <= n_pos;
            r_last_zero   <= n_last_zero;
            r_last_branch <= n_last_branch;
            r_family      <= n_family;
            r_last_seen   <= n_last_seen;
            r_active      <= n_active;
            r_found       <= n_found;
        end
    end

    // An active pass always points at a real ROM bit
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_pos >= POS_W'(1) && r_pos <= POS_W'(ROM_BITS)))
        else $error("bit position out of range during pass");

    // Family mark stays within the family byte
    a_family_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_family < FAM_W'(FAMILY_LIMIT))
        else $error("family mark beyond family byte");

    // Two results only at the close of a pass
    a_two_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push_n == 2'd2) |=> !r_active)
        else $error("pass still active after closing results");

endmodule

@@ hdl/ows_result_fifo.sv @@
// ----------------------------------------------------------------------------
// ows_result_fifo
// Small result queue. Takes up to two results per cycle and presents the
// oldest one on the output channel until it is taken.
// ----------------------------------------------------------------------------
module ows_result_fifo import ows_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_result               i_res0,
    input  t_result               i_res1,
    input  logic [1:0]            i_push_n,
    input  logic                  i_pop,
    output t_result               o_head,
    output logic                  o_valid,
    output logic [FIFO_CNT_W-1:0] o_count
);

    t_result                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [FIFO_PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [FIFO_CNT_W-1:0]  r_count,  n_count;
    logic [FIFO_PTR_W-1:0]  wr_ptr1;
    logic                   pop_ok;

    assign wr_ptr1 = r_wr_ptr + FIFO_PTR_W'(1);
    assign pop_ok  = i_pop && (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign o_valid = (r_count != '0);
    assign o_count = r_count;

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr + FIFO_PTR_W'(i_push_n);
        n_rd_ptr = pop_ok ? r_rd_ptr + FIFO_PTR_W'(1) : r_rd_ptr;
        n_count  = r_count + FIFO_CNT_W'(i_push_n) - FIFO_CNT_W'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store incoming results
    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wr_ptr] <= i_res0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[wr_ptr1] <= i_res1;
        end
    end

    // Never overfill
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_n != 2'd0) |->
            ({1'b0, r_count} + {{FIFO_CNT_W-1{1'b0}}, i_push_n}) <= (FIFO_CNT_W+1)'(FIFO_DEPTH))
        else $error("result queue overflow");

    // Occupancy bounded by depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue count out of range");

endmodule

@@ hdl/onewire_rom_search.sv @@
// ----------------------------------------------------------------------------
// onewire_rom_search
// Decision logic of the 1-Wire search ROM tree walk: restart, pass start and
// bit-pair requests in, direction / found / not-found results out.
//
//   channel  dir  handshake                    payload
//   in       in   i_in_valid / o_in_stall      i_op i_presence i_id_bit
//                                              i_complement_bit
//   out      out  o_out_valid / i_out_stall    o_status o_direction_bit
//                                              o_found_rom o_last_device
//                                              o_family_mark o_found_count
//   cfg      in   i_cfg_valid / o_cfg_ready    i_cfg_data (device limit)
//
// One request per cycle while the input does not stall: a request enters
// the input register, is decided from there and its results land in a
// four-entry result queue; results reach the output from the queue head.
// The last bit pair of a pass gives two results; the queue absorbs them.
// Input stalls only when the queue has fewer than two free slots.
// Reset is synchronous, active low; the device limit resets to 8.
// ----------------------------------------------------------------------------
module onewire_rom_search import ows_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_op,
    input  logic                i_presence,
    input  logic                i_id_bit,
    input  logic                i_complement_bit,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [1:0]          o_status,
    output logic                o_direction_bit,
    output logic [ROM_BITS-1:0] o_found_rom,
    output logic                o_last_device,
    output logic [FAM_W-1:0]    o_family_mark,
    output logic [CNT_W-1:0]    o_found_count,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CNT_W-1:0]    i_cfg_data
);

    logic                  r_in_valid;
    t_item                 r_item;
    logic [CNT_W-1:0]      r_device_limit;
    logic                  in_accept;
    logic                  fire;
    t_result               res0;
    t_result               res1;
    logic [1:0]            push_n;
    t_result               head;
    logic [FIFO_CNT_W-1:0] q_count;

    // Decide a held request when the queue can take two results
    assign fire        = r_in_valid && (q_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign o_in_stall  = r_in_valid && !fire;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_accept || (r_in_valid && !fire);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.op             <= i_op;
            r_item.presence       <= i_presence;
            r_item.id_bit         <= i_id_bit;
            r_item.complement_bit <= i_complement_bit;
        end
    end

    // Device limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_limit <= CNT_W'(LIMIT_RESET);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_device_limit <= i_cfg_data;
        end
    end

    ows_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_item         (r_item),
        .i_device_limit (r_device_limit),
        .o_res0         (res0),
        .o_res1         (res1),
        .o_push_n       (push_n)
    );

    ows_result_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_res0   (res0),
        .i_res1   (res1),
        .i_push_n (push_n),
        .i_pop    (!i_out_stall),
        .o_head   (head),
        .o_valid  (o_out_valid),
        .o_count  (q_count)
    );

    // Drive the result payload from the queue head
    assign o_status        = head.status;
    assign o_direction_bit = head.direction_bit;
    assign o_found_rom     = head.found_rom;
    assign o_last_device   = head.last_device;
    assign o_family_mark   = head.family_mark;
    assign o_found_count   = head.found_count;

endmodule

@@ test/onewire_rom_search_test.sv @@
// ----------------------------------------------------------------------------
// onewire_rom_search_test
// Self-checking bench for the ROM search decision block. A small bus model
// answers each bit slot from a random device population, with noise mixed
// in, and a scoreboard predicts every direction, found and not-found result.
// ----------------------------------------------------------------------------
module onewire_rom_search_test import ows_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_SPARE    = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         ITEM_TARGET = 1500;
    localparam int         QUIET_AFTER = 1250;
    localparam int         HOLD_CYCLES = 150;
    localparam int         SETTLE      = 6;

    // Predicts the results of each request and checks what comes out
    class search_scoreboard;
        logic [CNT_W-1:0]    device_ceiling;
        logic [ROM_BITS-1:0] rom_reg;
        logic [POS_W-1:0]    bit_pos;
        logic [POS_W-1:0]    zero_in_pass;
        logic [POS_W-1:0]    branch_pos;
        logic [FAM_W-1:0]    family_pos;
        logic [CNT_W-1:0]    found_cnt;
        bit                  seen_last;
        bit                  pass_on;
        bit                  last_dir;
        t_result             expected_results[$];
        int                  errors;

        function new();
            device_ceiling = CNT_W'(LIMIT_RESET);
            rom_reg        = '0;
            bit_pos        = POS_W'(1);
            zero_in_pass   = '0;
            branch_pos     = '0;
            family_pos     = '0;
            found_cnt      = '0;
            seen_last      = 1'b0;
            pass_on        = 1'b0;
            last_dir       = 1'b0;
            errors         = 0;
        endfunction

        function void forget_branches();
            branch_pos = '0;
            family_pos = '0;
            seen_last  = 1'b0;
        endfunction

        function void push(logic [1:0] st, bit dir, logic [ROM_BITS-1:0] rom, bit last);
            t_result r;
            r.status        = st;
            r.direction_bit = dir;
            r.found_rom     = rom;
            r.last_device   = last;
            r.family_mark   = family_pos;
            r.found_count   = found_cnt;
            expected_results.push_back(r);
        endfunction

        // Note one accepted request; return 0 when the block ignores it
        function bit note_request(t_item it);
            int idx;
            bit dir;
            if (it.op == OP_RESTART) begin
                forget_branches();
                found_cnt = '0;
                pass_on   = 1'b0;
                return 1'b1;
            end
            if (it.op == OP_BEGIN) begin
                pass_on = 1'b0;
                if (found_cnt >= device_ceiling) begin
                    push(ST_NONE, 1'b0, '0, 1'b0);
                end else if (seen_last || !it.presence) begin
                    forget_branches();
                    push(ST_NONE, 1'b0, '0, 1'b0);
                end else begin
                    pass_on      = 1'b1;
                    bit_pos      = POS_W'(1);
                    zero_in_pass = '0;
                end
                return 1'b1;
            end
            if (it.op != OP_PAIR || !pass_on)
                return 1'b0;

            // Both bits high: nobody answered this slot
            if (it.id_bit && it.complement_bit) begin
                pass_on = 1'b0;
                forget_branches();
                push(ST_NONE, 1'b0, '0, 1'b0);
                return 1'b1;
            end

            idx = bit_pos - 1;
            if (it.id_bit != it.complement_bit) begin
                dir = it.id_bit;
            end else begin
                // Discrepancy: replay below the last branch, take 1 on it, 0 above
                if (bit_pos < branch_pos)
                    dir = rom_reg[idx];
                else
                    dir = (bit_pos == branch_pos);
                if (!dir) begin
                    zero_in_pass = bit_pos;
                    if (bit_pos < FAMILY_LIMIT)
                        family_pos = bit_pos[FAM_W-1:0];
                end
            end
            rom_reg[idx] = dir;
            last_dir     = dir;
            push(ST_DIR, dir, '0, 1'b0);
            bit_pos++;
            if (bit_pos <= ROM_BITS)
                return 1'b1;

            // Close the pass
            pass_on    = 1'b0;
            branch_pos = zero_in_pass;
            if (branch_pos == 0)
                seen_last = 1'b1;
            if (rom_reg[7:0] == 8'd0) begin
                forget_branches();
                push(ST_NONE, 1'b0, '0, 1'b0);
            end else begin
                if (found_cnt != 8'hFF)
                    found_cnt++;
                push(ST_FOUND, 1'b0, rom_reg, seen_last);
            end
            return 1'b1;
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: st=%0d dir=%0d rom=%h last=%0d fam=%0d cnt=%0d",
                             got.status, got.direction_bit, got.found_rom, got.last_device,
                             got.family_mark, got.found_count);
                return;
            end
            want = expected_results.pop_front();
            if (want.status != got.status || want.direction_bit != got.direction_bit ||
                want.found_rom != got.found_rom || want.last_device != got.last_device ||
                want.family_mark != got.family_mark || want.found_count != got.found_count)
            begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch exp: st=%0d dir=%0d rom=%h last=%0d fam=%0d cnt=%0d",
                             want.status, want.direction_bit, want.found_rom, want.last_device,
                             want.family_mark, want.found_count);
                    $display("         got: st=%0d dir=%0d rom=%h last=%0d fam=%0d cnt=%0d",
                             got.status, got.direction_bit, got.found_rom, got.last_device,
                             got.family_mark, got.found_count);
                end
            end
        endfunction
    endclass

    logic                i_clk            = 1'b0;
    logic                i_rst_n          = 1'b0;
    logic                i_in_valid       = 1'b0;
    logic                o_in_stall;
    logic [1:0]          i_op             = OP_RESTART;
    logic                i_presence       = 1'b0;
    logic                i_id_bit         = 1'b0;
    logic                i_complement_bit = 1'b0;
    logic                o_out_valid;
    logic                i_out_stall      = 1'b0;
    logic [1:0]          o_status;
    logic                o_direction_bit;
    logic [ROM_BITS-1:0] o_found_rom;
    logic                o_last_device;
    logic [FAM_W-1:0]    o_family_mark;
    logic [CNT_W-1:0]    o_found_count;
    logic                i_cfg_valid      = 1'b0;
    logic                o_cfg_ready;
    logic [CNT_W-1:0]    i_cfg_data       = '0;

    search_scoreboard    sb = new();
    t_result             out_word;
    int                  handled_cnt = 0;
    int                  cycle_cnt   = 0;
    int                  hold_req    = 0;
    int                  hold_ack    = 0;
    int                  hold_left   = 0;
    int                  stall_left  = 0;
    bit                  send_gaps   = 1'b1;
    bit                  stall_gaps  = 1'b1;

    // Bus model: device ROMs and which of them still take part in the pass
    bit [ROM_BITS-1:0]   bus_roms[$];
    bit                  alive[$];

    onewire_rom_search uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_op             (i_op),
        .i_presence       (i_presence),
        .i_id_bit         (i_id_bit),
        .i_complement_bit (i_complement_bit),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_direction_bit  (o_direction_bit),
        .o_found_rom      (o_found_rom),
        .o_last_device    (o_last_device),
        .o_family_mark    (o_family_mark),
        .o_found_count    (o_found_count),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    always_comb begin
        out_word.status        = o_status;
        out_word.direction_bit = o_direction_bit;
        out_word.found_rom     = o_found_rom;
        out_word.last_device   = o_last_device;
        out_word.family_mark   = o_family_mark;
        out_word.found_count   = o_found_count;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result side: check each accepted result, then pick the next stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall)
                sb.check_result(out_word);
            if (hold_ack != hold_req) begin
                hold_ack    <= hold_req;
                hold_left   <= HOLD_CYCLES - 1;
                i_out_stall <= 1'b1;
            end else if (hold_left != 0) begin
                hold_left   <= hold_left - 1;
                i_out_stall <= 1'b1;
            end else if (stall_left != 0) begin
                stall_left  <= stall_left - 1;
                i_out_stall <= 1'b1;
            end else if (stall_gaps && $urandom_range(0, 5) == 0) begin
                stall_left  <= $urandom_range(0, 7);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    function automatic bit coin();
        return 1'($urandom_range(0, 1));
    endfunction

    // Offer one request and hold it until taken
    task automatic send_request(input logic [1:0] op, input bit pres, input bit idb,
                                input bit cmpb);
        t_item it;
        it.op             = op;
        it.presence       = pres;
        it.id_bit         = idb;
        it.complement_bit = cmpb;
        if (send_gaps && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_op             <= op;
        i_presence       <= pres;
        i_id_bit         <= idb;
        i_complement_bit <= cmpb;
        do @(posedge i_clk); while (o_in_stall);
        handled_cnt += sb.note_request(it);
    endtask

    // Drop valid, drain every expected result, then let the pipeline empty
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [CNT_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid       <= 1'b0;
        sb.device_ceiling  = value;
    endtask

    // Fill the bus with random devices, some near-copies for deep branches
    task automatic build_bus(input int n_dev);
        bit [ROM_BITS-1:0] r;
        bus_roms.delete();
        alive.delete();
        for (int i = 0; i < n_dev; i++) begin
            r = {$urandom, $urandom};
            if (i > 0 && $urandom_range(0, 2) == 0)
                r = bus_roms[$urandom_range(0, i - 1)] ^ (64'd1 << $urandom_range(8, 63));
            if ($urandom_range(0, 5) == 0)
                r[7:0] = 8'd0;
            bus_roms.push_back(r);
            alive.push_back(1'b1);
        end
    endtask

    // One search pass: answer each slot as a wired-AND bus would
    task automatic run_pass(input bit noisy);
        bit pres;
        bit idb;
        bit cmpb;
        pres = (bus_roms.size() != 0);
        if (noisy && $urandom_range(0, 19) == 0)
            pres = !pres;
        send_request(OP_BEGIN, pres, coin(), coin());
        for (int d = 0; d < alive.size(); d++)
            alive[d] = 1'b1;
        for (int k = 0; k < ROM_BITS && sb.pass_on; k++) begin
            if (noisy && $urandom_range(0, 149) == 0)
                send_request(2'($urandom_range(0, 3)), coin(), coin(), coin());
            idb  = 1'b1;
            cmpb = 1'b1;
            for (int d = 0; d < bus_roms.size(); d++) begin
                if (alive[d]) begin
                    idb  &= bus_roms[d][k];
                    cmpb &= !bus_roms[d][k];
                end
            end
            if (noisy && $urandom_range(0, 32) == 0) begin
                idb  = coin();
                cmpb = coin();
            end
            send_request(OP_PAIR, coin(), idb, cmpb);
            // Devices that disagree with the written bit drop out
            for (int d = 0; d < bus_roms.size(); d++)
                if (alive[d] && bus_roms[d][k] != sb.last_dir)
                    alive[d] = 1'b0;
        end
    endtask

    task automatic run_enumeration(input int n_dev, input int n_pass);
        build_bus(n_dev);
        send_request(OP_RESTART, coin(), coin(), coin());
        repeat (n_pass) run_pass(1'b1);
    endtask

    initial begin
        int               phase;
        int               n_dev;
        logic [CNT_W-1:0] lim;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: ignored requests, no presence, each pair kind, re-arm, abort
        send_request(OP_RESTART, 1'b1, 1'b1, 1'b1);
        send_request(OP_PAIR, 1'b0, 1'b0, 1'b1);
        send_request(OP_SPARE, 1'b1, 1'b1, 1'b0);
        send_request(OP_BEGIN, 1'b0, 1'b1, 1'b1);
        send_request(OP_BEGIN, 1'b1, 1'b0, 1'b0);
        send_request(OP_PAIR, 1'b1, 1'b0, 1'b1);
        send_request(OP_PAIR, 1'b0, 1'b1, 1'b0);
        send_request(OP_PAIR, 1'b1, 1'b0, 1'b0);
        send_request(OP_SPARE, 1'b0, 1'b0, 1'b0);
        send_request(OP_BEGIN, 1'b1, 1'b1, 1'b0);
        send_request(OP_PAIR, 1'b0, 1'b0, 1'b0);
        send_request(OP_PAIR, 1'b1, 1'b1, 1'b1);
        send_request(OP_PAIR, 1'b0, 1'b1, 1'b0);
        send_request(OP_BEGIN, 1'b1, 1'b0, 1'b1);
        send_request(OP_PAIR, 1'b0, 1'b0, 1'b0);
        send_request(OP_RESTART, 1'b0, 1'b0, 1'b0);
        send_request(OP_PAIR, 1'b1, 1'b0, 1'b1);

        // Limit of zero: every pass start reports nothing found
        wait_idle();
        write_limit(8'd0);
        send_request(OP_BEGIN, 1'b1, 1'b0, 1'b0);
        send_request(OP_RESTART, 1'b1, 1'b1, 1'b1);
        send_request(OP_BEGIN, 1'b1, 1'b1, 1'b1);

        // Random enumerations under a range of limits
        phase = 0;
        while (handled_cnt < ITEM_TARGET) begin
            if (handled_cnt > QUIET_AFTER) begin
                send_gaps  = 1'b0;
                stall_gaps = 1'b0;
            end
            unique case (phase)
                0:       lim = 8'd255;
                1:       lim = 8'd0;
                2:       lim = 8'd1;
                3:       lim = 8'd3;
                4:       lim = 8'd255;
                default: lim = CNT_W'($urandom_range(1, 12));
            endcase
            wait_idle();
            write_limit(lim);
            n_dev = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
            // Hold the result side off while requests keep coming
            if (phase == 2) begin
                hold_req  <= hold_req + 1;
                send_gaps  = 1'b0;
                n_dev      = 2;
            end
            run_enumeration(n_dev, $urandom_range(2, n_dev + 2));
            send_gaps = (handled_cnt <= QUIET_AFTER);
            phase++;
        end

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
